/* rtl/core/assert_macros.svh */
// shared assertion macros, clocked on clk and held off during reset
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property must hold at every edge out of reset
`define ASSERT_CLK(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// condition must never be seen out of reset
`define ASSERT_NEVER(label, cond, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) else $error(msg);

`endif

/* rtl/core/asipr_pkg.sv */
package asipr_pkg;

  localparam int DEPTH    = 256;
  localparam int WORD_W   = 32;
  localparam int CNT_W    = $clog2(DEPTH + 1);
  localparam int LEN_W    = 9;
  localparam int IDX_IN_W = 9;
  localparam int STEP_W   = 16;
  localparam int BIT_W    = $clog2(STEP_W);
  localparam int CMP_W    = (CNT_W > STEP_W) ? CNT_W : STEP_W;

  // read tree: groups of cells reduced first, then the group results
  localparam int GRP   = 16;
  localparam int GRP_W = $clog2(GRP);
  localparam int NGRP  = (DEPTH + GRP - 1) / GRP;
  localparam int LANES = NGRP * GRP;

  typedef logic [WORD_W-1:0] word_t;
  typedef logic [CNT_W-1:0]  cnt_t;

  typedef enum logic [2:0] {
    CELL_HOLD,
    CELL_CLEAR,
    CELL_WRITE,
    CELL_INSERT,
    CELL_REMOVE,
    CELL_ROTL
  } cell_op_t;

  // broadcast to every cell
  typedef struct packed {
    cell_op_t op;
    cnt_t     idx;
    cnt_t     cnt;
    cnt_t     cnt_m1;
    word_t    value;
  } cell_ctrl_t;

  typedef struct packed {
    word_t            word;
    logic             hit;
    logic [GRP_W-1:0] ofs;
  } grp_res_t;

  typedef struct packed {
    word_t word;
    logic  hit;
    cnt_t  pos;
  } rd_res_t;

endpackage

/* rtl/core/array_store_insert_pop_rotate_top.sv */
// channel  direction  handshake             payload
// in       input      in_valid / in_ready   in_req_type in_index in_value in_step
// out      output     out_valid / out_ready out_data out_length out_status
// cfg      input      cfg_we                cfg_initial_length
//
// one word at a time; in_ready is high only while no word is in progress
// set, append, insert, rotate left, errors: one pass through the cell row
// get, front, back, find, remove: two registered levels of the read tree
// rotate right: a serial remainder of the step, then one rotate-left pass of the row per
// cycle, (length - step mod length) passes when the remainder is nonzero
// reset and cfg writes clear every cell; a waiting result is held in the
// output register and only a word finishing behind it stalls
`include "assert_macros.svh"

module array_store_insert_pop_rotate_top import asipr_pkg::*; (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       in_valid,
  output logic                       in_ready,
  input  logic [3:0]                 in_req_type,
  input  logic [IDX_IN_W-1:0]        in_index,
  input  logic signed [WORD_W-1:0]   in_value,
  input  logic [STEP_W-1:0]          in_step,
  output logic                       out_valid,
  input  logic                       out_ready,
  output logic signed [WORD_W-1:0]   out_data,
  output logic [LEN_W-1:0]           out_length,
  output logic [2:0]                 out_status,
  input  logic                       cfg_we,
  input  logic [LEN_W-1:0]           cfg_initial_length
);

  localparam logic [3:0] REQ_GET    = 4'd0;
  localparam logic [3:0] REQ_SET    = 4'd1;
  localparam logic [3:0] REQ_FIND   = 4'd2;
  localparam logic [3:0] REQ_FRONT  = 4'd3;
  localparam logic [3:0] REQ_BACK   = 4'd4;
  localparam logic [3:0] REQ_APPEND = 4'd5;
  localparam logic [3:0] REQ_INSERT = 4'd6;
  localparam logic [3:0] REQ_ROTR   = 4'd7;
  localparam logic [3:0] REQ_ROTL   = 4'd8;
  localparam logic [3:0] REQ_REMOVE = 4'd9;

  localparam logic [2:0] ST_OK       = 3'd0;
  localparam logic [2:0] ST_RANGE    = 3'd1;
  localparam logic [2:0] ST_FULL     = 3'd2;
  localparam logic [2:0] ST_EMPTY    = 3'd3;
  localparam logic [2:0] ST_NOTFOUND = 3'd4;

  typedef enum logic [2:0] {
    S_IDLE,
    S_RD1,
    S_RD2,
    S_RD3,
    S_MOD,
    S_ROT,
    S_DONE
  } state_t;

  state_t             state_r,      state_nxt;
  cell_ctrl_t         ctrl_r,       ctrl_nxt;
  cnt_t               count_r,      count_nxt;
  logic [3:0]         req_r,        req_nxt;
  word_t              res_data_r,   res_data_nxt;
  logic [2:0]         res_status_r, res_status_nxt;
  cnt_t               rem_r,        rem_nxt;
  logic [STEP_W-1:0]  step_r,       step_nxt;
  logic [BIT_W-1:0]   bit_cnt_r,    bit_cnt_nxt;
  logic               out_valid_r,  out_valid_nxt;
  word_t              out_data_r,   out_data_nxt;
  logic [LEN_W-1:0]   out_length_r, out_length_nxt;
  logic [2:0]         out_status_r, out_status_nxt;

  rd_res_t            rd;
  logic [CMP_W-1:0]   idx_w;
  logic [CMP_W-1:0]   cnt_w;
  logic [CNT_W:0]     rem_t;

  asipr_array u_array (
    .clk   (clk),
    .rst_n (rst_n),
    .ctrl  (ctrl_r),
    .rd    (rd)
  );

  assign idx_w = CMP_W'(in_index);
  assign cnt_w = CMP_W'(count_r);

  always_comb begin
    state_nxt      = state_r;
    ctrl_nxt       = ctrl_r;
    ctrl_nxt.op    = CELL_HOLD;
    ctrl_nxt.cnt   = count_r;
    ctrl_nxt.cnt_m1 = count_r - cnt_t'(1);
    count_nxt      = count_r;
    req_nxt        = req_r;
    res_data_nxt   = res_data_r;
    res_status_nxt = res_status_r;
    rem_nxt        = rem_r;
    step_nxt       = step_r;
    bit_cnt_nxt    = bit_cnt_r;
    out_valid_nxt  = out_valid_r && !out_ready;
    out_data_nxt   = out_data_r;
    out_length_nxt = out_length_r;
    out_status_nxt = out_status_r;
    rem_t          = '0;

    unique case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          req_nxt        = in_req_type;
          res_data_nxt   = '0;
          res_status_nxt = ST_OK;
          ctrl_nxt.idx   = idx_w[CNT_W-1:0];
          ctrl_nxt.value = in_value;
          state_nxt      = S_DONE;
          unique case (in_req_type) inside
            REQ_GET, REQ_REMOVE: begin
              if (idx_w < cnt_w) state_nxt = S_RD1;
              else res_status_nxt = ST_RANGE;
            end
            REQ_SET: begin
              if (idx_w < cnt_w) ctrl_nxt.op = CELL_WRITE;
              else res_status_nxt = ST_RANGE;
            end
            REQ_FIND: begin
              state_nxt = S_RD1;
            end
            REQ_FRONT: begin
              ctrl_nxt.idx = '0;
              if (count_r == '0) res_status_nxt = ST_EMPTY;
              else state_nxt = S_RD1;
            end
            REQ_BACK: begin
              ctrl_nxt.idx = count_r - cnt_t'(1);
              if (count_r == '0) res_status_nxt = ST_EMPTY;
              else state_nxt = S_RD1;
            end
            REQ_APPEND: begin
              ctrl_nxt.idx = count_r;
              if (cnt_w >= CMP_W'(DEPTH)) begin
                res_status_nxt = ST_FULL;
              end else begin
                ctrl_nxt.op = CELL_WRITE;
                count_nxt   = count_r + cnt_t'(1);
              end
            end
            REQ_INSERT: begin
              if (idx_w > cnt_w) begin
                res_status_nxt = ST_RANGE;
              end else if (cnt_w >= CMP_W'(DEPTH)) begin
                res_status_nxt = ST_FULL;
              end else begin
                ctrl_nxt.op = CELL_INSERT;
                count_nxt   = count_r + cnt_t'(1);
              end
            end
            REQ_ROTR: begin
              if (count_r == '0) begin
                res_status_nxt = ST_EMPTY;
              end else begin
                rem_nxt     = '0;
                step_nxt    = in_step;
                bit_cnt_nxt = BIT_W'(STEP_W - 1);
                state_nxt   = S_MOD;
              end
            end
            REQ_ROTL: begin
              if (count_r == '0) res_status_nxt = ST_EMPTY;
              else ctrl_nxt.op = CELL_ROTL;
            end
            default: begin
              res_status_nxt = ST_OK;
            end
          endcase
        end
      end
      S_RD1: begin
        state_nxt = S_RD2;
      end
      S_RD2: begin
        state_nxt = S_RD3;
      end
      S_RD3: begin
        state_nxt = S_DONE;
        if (req_r == REQ_FIND) begin
          if (rd.hit) begin
            res_data_nxt = WORD_W'(rd.pos);
          end else begin
            res_data_nxt   = '1;
            res_status_nxt = ST_NOTFOUND;
          end
        end else begin
          res_data_nxt = rd.word;
          if (req_r == REQ_REMOVE) begin
            ctrl_nxt.op = CELL_REMOVE;
            count_nxt   = count_r - cnt_t'(1);
          end
        end
      end
      S_MOD: begin
        // restoring remainder, one step bit per cycle
        rem_t = {rem_r, step_r[STEP_W-1]};
        if (rem_t >= {1'b0, count_r}) rem_t = rem_t - {1'b0, count_r};
        rem_nxt  = rem_t[CNT_W-1:0];
        step_nxt = step_r << 1;
        bit_cnt_nxt = bit_cnt_r - BIT_W'(1);
        if (bit_cnt_r == '0) state_nxt = S_ROT;
      end
      S_ROT: begin
        // right by r equals left by one, (length - r) times
        if (rem_r == '0 || rem_r == count_r) begin
          state_nxt = S_DONE;
        end else begin
          ctrl_nxt.op = CELL_ROTL;
          rem_nxt     = rem_r + cnt_t'(1);
        end
      end
      S_DONE: begin
        if (!out_valid_r || out_ready) begin
          out_valid_nxt  = 1'b1;
          out_data_nxt   = res_data_r;
          out_length_nxt = LEN_W'(count_r);
          out_status_nxt = res_status_r;
          state_nxt      = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase

    if (cfg_we) begin
      ctrl_nxt.op = CELL_CLEAR;
      if (CMP_W'(cfg_initial_length) > CMP_W'(DEPTH)) count_nxt = CNT_W'(DEPTH);
      else count_nxt = CNT_W'(cfg_initial_length);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      ctrl_r      <= '0;
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      ctrl_r      <= ctrl_nxt;
      count_r     <= count_nxt;
      out_valid_r <= out_valid_nxt;
    end
    req_r        <= req_nxt;
    res_data_r   <= res_data_nxt;
    res_status_r <= res_status_nxt;
    rem_r        <= rem_nxt;
    step_r       <= step_nxt;
    bit_cnt_r    <= bit_cnt_nxt;
    out_data_r   <= out_data_nxt;
    out_length_r <= out_length_nxt;
    out_status_r <= out_status_nxt;
  end

  assign in_ready   = (state_r == S_IDLE);
  assign out_valid  = out_valid_r;
  assign out_data   = out_data_r;
  assign out_length = out_length_r;
  assign out_status = out_status_r;

  `ASSERT_NEVER(a_count_max, count_r > CNT_W'(DEPTH), "length above capacity")
  `ASSERT_CLK(a_out_from_done, $rose(out_valid_r) |-> $past(state_r == S_DONE), "result not from done state")
  `ASSERT_CLK(a_cell_op_busy, (ctrl_r.op != CELL_HOLD && ctrl_r.op != CELL_CLEAR) |-> (state_r == S_DONE || state_r == S_ROT), "cell update while idle")
  `ASSERT_CLK(a_rot_bound, (state_r == S_ROT) |-> (rem_r <= count_r), "rotation counter past length")

endmodule

/* rtl/core/asipr_cell.sv */
module asipr_cell import asipr_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  input  cell_ctrl_t ctrl,
  input  cnt_t       pos,
  input  word_t      left_word,
  input  word_t      right_word,
  input  word_t      head_word,
  output word_t      word,
  output word_t      rd_word,
  output logic       hit
);

  word_t word_r;
  word_t word_nxt;

  always_comb begin
    word_nxt = word_r;
    unique case (ctrl.op)
      CELL_HOLD: begin
        word_nxt = word_r;
      end
      CELL_CLEAR: begin
        word_nxt = '0;
      end
      CELL_WRITE: begin
        if (pos == ctrl.idx) word_nxt = ctrl.value;
      end
      CELL_INSERT: begin
        // open a slot at idx, everything up to the old end moves up one
        if (pos == ctrl.idx) begin
          word_nxt = ctrl.value;
        end else if (pos > ctrl.idx && pos <= ctrl.cnt) begin
          word_nxt = left_word;
        end
      end
      CELL_REMOVE: begin
        if (pos >= ctrl.idx && pos < ctrl.cnt_m1) word_nxt = right_word;
      end
      CELL_ROTL: begin
        // last valid cell takes the old front word
        if (pos < ctrl.cnt_m1) begin
          word_nxt = right_word;
        end else if (pos == ctrl.cnt_m1) begin
          word_nxt = head_word;
        end
      end
      default: begin
        word_nxt = word_r;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      word_r <= '0;
    end else begin
      word_r <= word_nxt;
    end
  end

  assign word    = word_r;
  assign rd_word = (pos == ctrl.idx) ? word_r : '0;
  assign hit     = (word_r == ctrl.value) && (pos < ctrl.cnt);

endmodule

/* rtl/core/asipr_group.sv */
module asipr_group import asipr_pkg::*; (
  input  logic           clk,
  input  word_t          rd_word [GRP],
  input  logic [GRP-1:0] hit,
  output grp_res_t       res
);

  grp_res_t res_r;
  grp_res_t res_nxt;

  always_comb begin
    res_nxt.word = '0;
    res_nxt.ofs  = '0;
    for (int k = 0; k < GRP; k++) begin
      res_nxt.word = res_nxt.word | rd_word[k];
    end
    // lowest matching lane wins
    for (int k = GRP - 1; k >= 0; k--) begin
      if (hit[k]) res_nxt.ofs = GRP_W'(k);
    end
    res_nxt.hit = |hit;
  end

  always_ff @(posedge clk) begin
    res_r <= res_nxt;
  end

  assign res = res_r;

endmodule

/* rtl/core/asipr_array.sv */
module asipr_array import asipr_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  input  cell_ctrl_t ctrl,
  output rd_res_t    rd
);

  word_t          cell_word [DEPTH];
  word_t          lane_rd   [NGRP][GRP];
  logic [GRP-1:0] lane_hit  [NGRP];
  grp_res_t       grp_res   [NGRP];
  rd_res_t        rd_r;
  rd_res_t        rd_nxt;

  for (genvar i = 0; i < LANES; i++) begin : g_lane
    if (i < DEPTH) begin : g_cell
      word_t left_w;
      word_t right_w;

      if (i == 0) begin : g_first
        assign left_w = '0;
      end else begin : g_left
        assign left_w = cell_word[i-1];
      end

      if (i == DEPTH - 1) begin : g_last
        assign right_w = '0;
      end else begin : g_right
        assign right_w = cell_word[i+1];
      end

      asipr_cell u_cell (
        .clk        (clk),
        .rst_n      (rst_n),
        .ctrl       (ctrl),
        .pos        (CNT_W'(i)),
        .left_word  (left_w),
        .right_word (right_w),
        .head_word  (cell_word[0]),
        .word       (cell_word[i]),
        .rd_word    (lane_rd[i/GRP][i%GRP]),
        .hit        (lane_hit[i/GRP][i%GRP])
      );
    end else begin : g_pad
      assign lane_rd[i/GRP][i%GRP]  = '0;
      assign lane_hit[i/GRP][i%GRP] = 1'b0;
    end
  end

  for (genvar g = 0; g < NGRP; g++) begin : g_grp
    asipr_group u_group (
      .clk     (clk),
      .rd_word (lane_rd[g]),
      .hit     (lane_hit[g]),
      .res     (grp_res[g])
    );
  end

  always_comb begin
    rd_nxt.word = '0;
    rd_nxt.hit  = 1'b0;
    rd_nxt.pos  = '0;
    for (int g = 0; g < NGRP; g++) begin
      rd_nxt.word = rd_nxt.word | grp_res[g].word;
      rd_nxt.hit  = rd_nxt.hit | grp_res[g].hit;
    end
    for (int g = NGRP - 1; g >= 0; g--) begin
      if (grp_res[g].hit) rd_nxt.pos = CNT_W'(g * GRP) + CNT_W'(grp_res[g].ofs);
    end
  end

  always_ff @(posedge clk) begin
    rd_r <= rd_nxt;
  end

  assign rd = rd_r;

endmodule

/* tb/asipr_tb_pkg.sv */
package asipr_tb_pkg;

  typedef enum logic [3:0] {
    REQ_GET,
    REQ_SET,
    REQ_FIND,
    REQ_FRONT,
    REQ_BACK,
    REQ_APPEND,
    REQ_INSERT,
    REQ_ROT_RIGHT,
    REQ_ROT_LEFT,
    REQ_REMOVE
  } req_code_t;

  // codes above the last operation leave the store unchanged and are answered with status ok
  localparam int REQ_UNKNOWN_LO = int'(REQ_REMOVE) + 1;
  localparam int REQ_CODE_MAX   = 15;

  typedef enum logic [2:0] {
    ST_OK,
    ST_RANGE,
    ST_FULL,
    ST_EMPTY,
    ST_NOT_FOUND
  } status_t;

endpackage

/* tb/store_reply_checker.sv */
module store_reply_checker import asipr_pkg::*; import asipr_tb_pkg::*; (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     in_valid,
  input  logic                     in_ready,
  input  logic [3:0]               in_req_type,
  input  logic [IDX_IN_W-1:0]      in_index,
  input  logic signed [WORD_W-1:0] in_value,
  input  logic [STEP_W-1:0]        in_step,
  input  logic                     out_valid,
  input  logic                     out_ready,
  input  logic signed [WORD_W-1:0] out_data,
  input  logic [LEN_W-1:0]         out_length,
  input  logic [2:0]               out_status,
  input  logic                     cfg_we,
  input  logic [LEN_W-1:0]         cfg_initial_length,
  output int                       fail_count,
  output int                       awaiting,
  output logic [LEN_W-1:0]         model_len
);
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct {
    logic signed [WORD_W-1:0] data;
    logic [LEN_W-1:0]         length;
    status_t                  status;
  } reply_t;

  word_t       store_mem [DEPTH];
  int unsigned store_len;
  reply_t      pending_replies [$];
  int          mismatches = 0;

  assign fail_count = mismatches;

  function automatic void clear_store();
    for (int i = 0; i < DEPTH; i++) begin
      store_mem[i] = '0;
    end
  endfunction

  // entry i moves to (i + k) mod length
  function automatic void rotate_store(int unsigned k);
    word_t spill [DEPTH];
    if (store_len == 0 || k == 0) return;
    for (int unsigned i = 0; i < store_len; i++) begin
      spill[(i + k) % store_len] = store_mem[i];
    end
    for (int unsigned i = 0; i < store_len; i++) begin
      store_mem[i] = spill[i];
    end
  endfunction

  function automatic reply_t apply_request(logic [3:0] code, logic [IDX_IN_W-1:0] idx,
                                           word_t val, logic [STEP_W-1:0] step);
    reply_t r;
    r.data   = '0;
    r.status = ST_OK;
    case (code)
      REQ_GET: begin
        if (idx < store_len) r.data = store_mem[idx];
        else r.status = ST_RANGE;
      end
      REQ_SET: begin
        if (idx < store_len) store_mem[idx] = val;
        else r.status = ST_RANGE;
      end
      REQ_FIND: begin
        r.status = ST_NOT_FOUND;
        r.data   = '1;
        for (int unsigned i = 0; i < store_len; i++) begin
          if (store_mem[i] == val) begin
            r.status = ST_OK;
            r.data   = i;
            break;
          end
        end
      end
      REQ_FRONT: begin
        if (store_len == 0) r.status = ST_EMPTY;
        else r.data = store_mem[0];
      end
      REQ_BACK: begin
        if (store_len == 0) r.status = ST_EMPTY;
        else r.data = store_mem[store_len-1];
      end
      REQ_APPEND: begin
        if (store_len >= DEPTH) r.status = ST_FULL;
        else begin
          store_mem[store_len] = val;
          store_len++;
        end
      end
      REQ_INSERT: begin
        if (idx > store_len) r.status = ST_RANGE;
        else if (store_len >= DEPTH) r.status = ST_FULL;
        else begin
          for (int unsigned i = store_len; i > idx; i--) begin
            store_mem[i] = store_mem[i-1];
          end
          store_mem[idx] = val;
          store_len++;
        end
      end
      REQ_ROT_RIGHT: begin
        if (store_len == 0) r.status = ST_EMPTY;
        else rotate_store(step % store_len);
      end
      REQ_ROT_LEFT: begin
        if (store_len == 0) r.status = ST_EMPTY;
        else rotate_store(store_len - 1);
      end
      REQ_REMOVE: begin
        if (idx >= store_len) r.status = ST_RANGE;
        else begin
          r.data = store_mem[idx];
          for (int unsigned i = idx; i + 1 < store_len; i++) begin
            store_mem[i] = store_mem[i+1];
          end
          store_len--;
        end
      end
      default: ;
    endcase
    r.length = store_len[LEN_W-1:0];
    return r;
  endfunction

  task automatic flag_field(string name, logic signed [WORD_W-1:0] want_v,
                            logic signed [WORD_W-1:0] got_v);
    mismatches++;
    $error("%s expected %0d got %0d", name, want_v, got_v);
  endtask

  always @(posedge clk) begin
    reply_t want;
    reply_t fresh;
    if (!rst_n) begin
      clear_store();
      store_len = 0;
      pending_replies.delete();
      awaiting  <= 0;
      model_len <= '0;
    end else begin
      // results first: a word accepted at this edge cannot already be answered
      if (out_valid && out_ready) begin
        if (pending_replies.size() == 0) begin
          mismatches++;
          $error("unexpected result: data %0d length %0d status %0d",
                 out_data, out_length, out_status);
        end else begin
          want = pending_replies.pop_front();
          if (out_data !== want.data) flag_field("data", want.data, out_data);
          if (out_length !== want.length)
            flag_field("length", WORD_W'(want.length), WORD_W'(out_length));
          if (out_status !== want.status)
            flag_field("status", WORD_W'(want.status), WORD_W'(out_status));
        end
      end
      if (cfg_we) begin
        clear_store();
        store_len = (cfg_initial_length > DEPTH) ? DEPTH : cfg_initial_length;
      end
      if (in_valid && in_ready) begin
        fresh = apply_request(in_req_type, in_index, in_value, in_step);
        pending_replies.insert(pending_replies.size(), fresh);
      end
      awaiting  <= pending_replies.size();
      model_len <= store_len[LEN_W-1:0];
    end
  end

endmodule

/* tb/array_store_insert_pop_rotate_top_tb.sv */
module array_store_insert_pop_rotate_top_tb;
  import asipr_pkg::*;
  import asipr_tb_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  logic                     clk = 1'b0;
  logic                     rst_n;
  logic                     in_valid;
  logic                     in_ready;
  logic [3:0]               in_req_type;
  logic [IDX_IN_W-1:0]      in_index;
  logic signed [WORD_W-1:0] in_value;
  logic [STEP_W-1:0]        in_step;
  logic                     out_valid;
  logic                     out_ready;
  logic signed [WORD_W-1:0] out_data;
  logic [LEN_W-1:0]         out_length;
  logic [2:0]               out_status;
  logic                     cfg_we;
  logic [LEN_W-1:0]         cfg_initial_length;

  int               fail_count;
  int               awaiting;
  logic [LEN_W-1:0] model_len;
  bit               calm = 1'b0;
  int               len_cap;

  always #4 clk = ~clk;

  array_store_insert_pop_rotate_top dut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_ready(in_ready),
    .in_req_type(in_req_type), .in_index(in_index), .in_value(in_value), .in_step(in_step),
    .out_valid(out_valid), .out_ready(out_ready),
    .out_data(out_data), .out_length(out_length), .out_status(out_status),
    .cfg_we(cfg_we), .cfg_initial_length(cfg_initial_length)
  );

  store_reply_checker checker_i (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_ready(in_ready),
    .in_req_type(in_req_type), .in_index(in_index), .in_value(in_value), .in_step(in_step),
    .out_valid(out_valid), .out_ready(out_ready),
    .out_data(out_data), .out_length(out_length), .out_status(out_status),
    .cfg_we(cfg_we), .cfg_initial_length(cfg_initial_length),
    .fail_count(fail_count), .awaiting(awaiting), .model_len(model_len)
  );

  function automatic int pick_gap();
    int r;
    if (calm) return 0;
    r = $urandom_range(0, 99);
    if (r < 50) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  task automatic send_word(logic [3:0] code, int idx, logic signed [WORD_W-1:0] val,
                           int step);
    int gap;
    gap = pick_gap();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid    <= 1'b1;
    in_req_type <= code;
    in_index    <= IDX_IN_W'(idx);
    in_value    <= val;
    in_step     <= STEP_W'(step);
    do @(posedge clk); while (!in_ready);
  endtask

  // hold the sender until every result is back, then let the block settle
  task automatic quiesce();
    in_valid <= 1'b0;
    do @(posedge clk); while (awaiting != 0);
    repeat (6) @(posedge clk);
  endtask

  task automatic load_length(int len);
    quiesce();
    cfg_we             <= 1'b1;
    cfg_initial_length <= LEN_W'(len);
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic random_word();
    int                       len, pick, idx, step, r;
    logic [3:0]               code;
    logic signed [WORD_W-1:0] val;
    len  = int'(model_len);
    pick = $urandom_range(0, 99);
    if (pick < 14) code = REQ_GET;
    else if (pick < 24) code = REQ_SET;
    else if (pick < 34) code = REQ_FIND;
    else if (pick < 38) code = REQ_FRONT;
    else if (pick < 42) code = REQ_BACK;
    else if (pick < 56) code = REQ_APPEND;
    else if (pick < 68) code = REQ_INSERT;
    else if (pick < 76) code = REQ_ROT_RIGHT;
    else if (pick < 81) code = REQ_ROT_LEFT;
    else if (pick < 96) code = REQ_REMOVE;
    else code = 4'($urandom_range(REQ_UNKNOWN_LO, REQ_CODE_MAX));
    // keep the length near the phase's working size
    if (len > len_cap && (code == REQ_APPEND || code == REQ_INSERT)) code = REQ_REMOVE;

    r = $urandom_range(0, 9);
    if (r < 7) idx = (len == 0) ? 0 : $urandom_range(0, len - 1);
    else if (r < 8) idx = len;
    else if (r < 9) idx = len + 1;
    else idx = $urandom_range(0, 2**IDX_IN_W - 1);

    r = $urandom_range(0, 9);
    if (r < 3) begin
      case ($urandom_range(0, 4))
        0: val = 32'sh7FFF_FFFF;
        1: val = 32'sh8000_0000;
        2: val = -1;
        default: val = $urandom_range(0, 7);
      endcase
    end else if (r < 5) val = $urandom_range(0, 15);
    else val = $urandom;

    if ($urandom_range(0, 9) < 6) step = $urandom_range(0, 2 * len + 2);
    else step = $urandom_range(0, 2**STEP_W - 1);

    send_word(code, idx, val, step);
  endtask

  always begin
    if (calm) begin
      out_ready <= 1'b1;
      @(posedge clk);
    end else begin
      out_ready <= 1'b1;
      repeat ($urandom_range(1, 6)) @(posedge clk);
      out_ready <= 1'b0;
      if ($urandom_range(0, 9) == 0) repeat ($urandom_range(8, 40)) @(posedge clk);
      else repeat ($urandom_range(1, 3)) @(posedge clk);
    end
  end

  initial begin
    int lens [8];
    int caps [8];
    rst_n              <= 1'b0;
    in_valid           <= 1'b0;
    in_req_type        <= '0;
    in_index           <= '0;
    in_value           <= '0;
    in_step            <= '0;
    cfg_we             <= 1'b0;
    cfg_initial_length <= '0;
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;

    // empty store after reset
    send_word(REQ_GET, 0, 0, 0);
    send_word(REQ_FRONT, 0, 0, 0);
    send_word(REQ_BACK, 0, 0, 0);
    send_word(REQ_ROT_RIGHT, 0, 0, 3);
    send_word(REQ_ROT_LEFT, 0, 0, 0);
    send_word(REQ_FIND, 0, 0, 0);
    send_word(REQ_REMOVE, 0, 0, 0);
    send_word(REQ_SET, 0, 5, 0);
    send_word(REQ_INSERT, 1, 5, 0);
    // build a short store, insert at the end included
    send_word(REQ_INSERT, 0, 32'sh8000_0000, 0);
    send_word(REQ_APPEND, 0, 32'sh7FFF_FFFF, 0);
    send_word(REQ_INSERT, 2, -1, 0);
    send_word(REQ_INSERT, 1, 7, 0);
    send_word(REQ_FIND, 0, -1, 0);
    send_word(REQ_ROT_RIGHT, 0, 0, 2**STEP_W - 1);
    send_word(REQ_ROT_RIGHT, 0, 0, 8);
    send_word(REQ_ROT_LEFT, 0, 0, 0);
    send_word(REQ_BACK, 0, 0, 0);
    send_word(REQ_REMOVE, 1, 0, 0);
    send_word(REQ_SET, 0, 32'sh5A5A_5A5A, 0);
    send_word(REQ_GET, 2**(IDX_IN_W-1), 0, 0);
    send_word(4'(REQ_UNKNOWN_LO), 0, 0, 0);
    send_word(4'(REQ_CODE_MAX), 2**IDX_IN_W - 1, -1, 2**STEP_W - 1);
    // full store
    load_length(DEPTH);
    send_word(REQ_APPEND, 0, 1, 0);
    send_word(REQ_INSERT, DEPTH, 1, 0);
    send_word(REQ_INSERT, DEPTH + 1, 1, 0);
    send_word(REQ_REMOVE, DEPTH - 1, 0, 0);
    // oversized length saturates
    load_length(2**LEN_W - 1);
    send_word(REQ_BACK, 0, 0, 0);

    lens = '{0, 1, 2, DEPTH, DEPTH - 1, 2**LEN_W - 1, $urandom_range(3, 40),
             $urandom_range(0, 2**LEN_W - 1)};
    caps = '{24, 12, 60, DEPTH, DEPTH, DEPTH, 40, 100};
    for (int p = 0; p < 8; p++) begin
      load_length(lens[p]);
      len_cap = caps[p];
      for (int n = 0; n < 250; n++) begin
        if (n % 50 == 0) calm = ($urandom_range(0, 3) == 0);
        if (n == 125) quiesce();
        random_word();
      end
    end

    calm = 1'b0;
    quiesce();
    repeat (30) @(posedge clk);
    if (fail_count == 0 && awaiting == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

  initial begin
    #30ms;
    $display("TB_ERROR");
    $finish;
  end

endmodule
